>>> sv/tpbc_pkg.sv
`timescale 1ns / 1ps
package tpbc_pkg;

    localparam int AXES         = 3;
    localparam int COORD_WIDTH  = 24;
    localparam int WEIGHT_WIDTH = 16;
    localparam int WSET_WIDTH   = AXES * WEIGHT_WIDTH;
    localparam int FRAC_SHIFT   = 12;
    localparam int PROD_WIDTH   = WEIGHT_WIDTH + COORD_WIDTH;
    localparam int DOT_WIDTH    = PROD_WIDTH + 2;
    localparam int SHIFT_WIDTH  = DOT_WIDTH - FRAC_SHIFT;
    localparam int BIAS_WIDTH   = SHIFT_WIDTH + 1;

    localparam int MAX_POINTS   = 65536;
    localparam int CNT_WIDTH    = $clog2(MAX_POINTS + 1);
    localparam int SUM_WIDTH    = COORD_WIDTH + CNT_WIDTH;
    localparam int STEP_WIDTH   = $clog2(SUM_WIDTH);

    localparam int FIFO_DEPTH   = 4;
    localparam int FIFO_AW      = $clog2(FIFO_DEPTH);

    localparam int APB_AW       = 6;
    localparam int APB_DW       = 64;
    localparam int REG_LSB      = 3;

    typedef logic signed [COORD_WIDTH-1:0] coord_t;

    localparam coord_t COORD_HI = {1'b0, {(COORD_WIDTH-1){1'b1}}};
    localparam coord_t COORD_LO = {1'b1, {(COORD_WIDTH-1){1'b0}}};

    localparam logic [WEIGHT_WIDTH-1:0] WEIGHT_ONE = WEIGHT_WIDTH'(1 << FRAC_SHIFT);

    typedef struct packed {
        coord_t [AXES-1:0] c;
        logic              last;
    } point_t;

    typedef struct packed {
        logic [AXES-1:0][WSET_WIDTH-1:0] w;
        coord_t [AXES-1:0]               off;
    } cfg_t;

    typedef enum logic [REG_LSB-1:0] {
        REG_X_WEIGHTS = 3'd0,
        REG_Y_WEIGHTS = 3'd1,
        REG_Z_WEIGHTS = 3'd2,
        REG_X_OFFSET  = 3'd3,
        REG_Y_OFFSET  = 3'd4,
        REG_Z_OFFSET  = 3'd5
    } reg_idx_t;

    typedef enum logic [1:0] {
        DIV_IDLE,
        DIV_RUN,
        DIV_DONE
    } div_state_t;

endpackage

>>> sv/tpbc_regs.sv
`timescale 1ns / 1ps
module tpbc_regs
    import tpbc_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0] prdata,
    output cfg_t              cfg
);

    cfg_t     cfg_reg;
    cfg_t     cfg_next;
    reg_idx_t idx;
    logic     wr_en;

    assign idx   = reg_idx_t'(paddr[APB_AW-1:REG_LSB]);
    assign wr_en = psel && penable && pwrite;
    assign cfg   = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            unique case (idx)
                REG_X_WEIGHTS: cfg_next.w[0]   = pwdata[WSET_WIDTH-1:0];
                REG_Y_WEIGHTS: cfg_next.w[1]   = pwdata[WSET_WIDTH-1:0];
                REG_Z_WEIGHTS: cfg_next.w[2]   = pwdata[WSET_WIDTH-1:0];
                REG_X_OFFSET:  cfg_next.off[0] = pwdata[COORD_WIDTH-1:0];
                REG_Y_OFFSET:  cfg_next.off[1] = pwdata[COORD_WIDTH-1:0];
                REG_Z_OFFSET:  cfg_next.off[2] = pwdata[COORD_WIDTH-1:0];
                default:       cfg_next        = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int a = 0; a < AXES; a++)
            begin
                cfg_reg.w[a]   <= WSET_WIDTH'(WEIGHT_ONE) << (WEIGHT_WIDTH * a);
                cfg_reg.off[a] <= '0;
            end
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    always_comb
    begin
        unique case (idx)
            REG_X_WEIGHTS: prdata = APB_DW'(cfg_reg.w[0]);
            REG_Y_WEIGHTS: prdata = APB_DW'(cfg_reg.w[1]);
            REG_Z_WEIGHTS: prdata = APB_DW'(cfg_reg.w[2]);
            REG_X_OFFSET:  prdata = APB_DW'($signed(cfg_reg.off[0]));
            REG_Y_OFFSET:  prdata = APB_DW'($signed(cfg_reg.off[1]));
            REG_Z_OFFSET:  prdata = APB_DW'($signed(cfg_reg.off[2]));
            default:       prdata = '0;
        endcase
    end

endmodule

>>> sv/tpbc_fifo.sv
`timescale 1ns / 1ps
module tpbc_fifo
    import tpbc_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   in_valid,
    output logic   in_ready,
    input  point_t in_item,
    output logic   out_valid,
    input  logic   out_ready,
    output point_t out_item
);

    point_t             mem_reg [FIFO_DEPTH];
    logic [FIFO_AW:0]   wr_ptr_reg;
    logic [FIFO_AW:0]   rd_ptr_reg;
    logic               full;
    logic               empty;
    logic               push;
    logic               pop;

    assign full      = (wr_ptr_reg ^ rd_ptr_reg) == {1'b1, {FIFO_AW{1'b0}}};
    assign empty     = wr_ptr_reg == rd_ptr_reg;
    assign in_ready  = !full;
    assign out_valid = !empty;
    assign push      = in_valid && !full;
    assign pop       = out_ready && !empty;
    assign out_item  = mem_reg[rd_ptr_reg[FIFO_AW-1:0]];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg[FIFO_AW-1:0]] <= in_item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
        end
    end

endmodule

>>> sv/tpbc_xform.sv
`timescale 1ns / 1ps
module tpbc_xform
    import tpbc_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  cfg_t   cfg,
    input  logic   in_valid,
    output logic   in_ready,
    input  point_t in_item,
    output logic   out_valid,
    input  logic   out_ready,
    output point_t out_item
);

    // stage 1: nine products, stage 2: dot, shift, offset, saturate
    logic signed [PROD_WIDTH-1:0] prod_reg [AXES][AXES];
    logic                         last1_reg;
    logic                         v1_reg;
    point_t                       s2_reg;
    logic                         v2_reg;
    logic                         adv;

    logic signed [DOT_WIDTH-1:0]   dot   [AXES];
    logic signed [SHIFT_WIDTH-1:0] shf   [AXES];
    logic signed [BIAS_WIDTH-1:0]  bias  [AXES];
    coord_t                        sat   [AXES];

    assign adv       = !v2_reg || out_ready;
    assign in_ready  = adv;
    assign out_valid = v2_reg;
    assign out_item  = s2_reg;

    always_comb
    begin
        for (int a = 0; a < AXES; a++)
        begin
            dot[a]  = DOT_WIDTH'(prod_reg[a][0]) + DOT_WIDTH'(prod_reg[a][1])
                    + DOT_WIDTH'(prod_reg[a][2]);
            shf[a]  = dot[a][DOT_WIDTH-1:FRAC_SHIFT];
            bias[a] = BIAS_WIDTH'(shf[a]) + BIAS_WIDTH'($signed(cfg.off[a]));
            if (bias[a] > BIAS_WIDTH'(COORD_HI))
            begin
                sat[a] = COORD_HI;
            end
            else if (bias[a] < BIAS_WIDTH'(COORD_LO))
            begin
                sat[a] = COORD_LO;
            end
            else
            begin
                sat[a] = bias[a][COORD_WIDTH-1:0];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int a = 0; a < AXES; a++)
            begin
                for (int b = 0; b < AXES; b++)
                begin
                    prod_reg[a][b] <= $signed(cfg.w[a][WEIGHT_WIDTH*b +: WEIGHT_WIDTH])
                                    * $signed(in_item.c[b]);
                end
                s2_reg.c[a] <= sat[a];
            end
            last1_reg   <= in_item.last;
            s2_reg.last <= last1_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else if (adv)
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
        end
    end

endmodule

>>> sv/tpbc_accum.sv
`timescale 1ns / 1ps
module tpbc_accum
    import tpbc_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   in_valid,
    output logic   in_ready,
    input  point_t in_item,
    output logic   out_valid,
    input  logic   out_ready,
    output coord_t min_x,
    output coord_t min_y,
    output coord_t min_z,
    output coord_t max_x,
    output coord_t max_y,
    output coord_t max_z,
    output coord_t mean_x,
    output coord_t mean_y,
    output coord_t mean_z
);

    div_state_t state_reg, state_next;

    coord_t                      lo_reg   [AXES], lo_next   [AXES];
    coord_t                      hi_reg   [AXES], hi_next   [AXES];
    logic signed [SUM_WIDTH-1:0] sum_reg  [AXES], sum_next  [AXES];
    logic [CNT_WIDTH-1:0]        cnt_reg, cnt_next;

    coord_t                      res_lo_reg [AXES], res_lo_next [AXES];
    coord_t                      res_hi_reg [AXES], res_hi_next [AXES];
    logic [SUM_WIDTH-1:0]        dvd_reg    [AXES], dvd_next    [AXES];
    logic [CNT_WIDTH-1:0]        rem_reg    [AXES], rem_next    [AXES];
    logic                        neg_reg    [AXES], neg_next    [AXES];
    logic [CNT_WIDTH-1:0]        dcnt_reg, dcnt_next;
    logic [STEP_WIDTH-1:0]       step_reg, step_next;

    coord_t                      upd_lo  [AXES];
    coord_t                      upd_hi  [AXES];
    logic signed [SUM_WIDTH-1:0] upd_sum [AXES];
    logic [CNT_WIDTH-1:0]        upd_cnt;
    logic [CNT_WIDTH:0]          rsh     [AXES];
    logic [CNT_WIDTH:0]          diff    [AXES];
    logic                        keep;
    logic                        take;

    // a last item may only enter once the divider is free
    assign in_ready = !(in_item.last && state_reg != DIV_IDLE);
    assign take     = in_valid && in_ready;
    assign keep     = cnt_reg != CNT_WIDTH'(MAX_POINTS);

    always_comb
    begin
        for (int a = 0; a < AXES; a++)
        begin
            upd_lo[a]  = lo_reg[a];
            upd_hi[a]  = hi_reg[a];
            upd_sum[a] = sum_reg[a];
            if (keep)
            begin
                if ($signed(in_item.c[a]) < lo_reg[a])
                begin
                    upd_lo[a] = in_item.c[a];
                end
                if ($signed(in_item.c[a]) > hi_reg[a])
                begin
                    upd_hi[a] = in_item.c[a];
                end
                upd_sum[a] = sum_reg[a] + SUM_WIDTH'($signed(in_item.c[a]));
            end
            rsh[a]  = {rem_reg[a], dvd_reg[a][SUM_WIDTH-1]};
            diff[a] = rsh[a] - {1'b0, dcnt_reg};
        end
        upd_cnt = keep ? cnt_reg + 1'b1 : cnt_reg;
    end

    always_comb
    begin
        state_next = state_reg;
        lo_next    = lo_reg;
        hi_next    = hi_reg;
        sum_next   = sum_reg;
        cnt_next   = cnt_reg;
        res_lo_next = res_lo_reg;
        res_hi_next = res_hi_reg;
        dvd_next   = dvd_reg;
        rem_next   = rem_reg;
        neg_next   = neg_reg;
        dcnt_next  = dcnt_reg;
        step_next  = step_reg;
        out_valid  = 1'b0;

        if (take)
        begin
            if (in_item.last)
            begin
                for (int a = 0; a < AXES; a++)
                begin
                    res_lo_next[a] = upd_lo[a];
                    res_hi_next[a] = upd_hi[a];
                    neg_next[a]    = upd_sum[a][SUM_WIDTH-1];
                    dvd_next[a]    = upd_sum[a][SUM_WIDTH-1] ? -upd_sum[a] : upd_sum[a];
                    rem_next[a]    = '0;
                    lo_next[a]     = COORD_HI;
                    hi_next[a]     = COORD_LO;
                    sum_next[a]    = '0;
                end
                dcnt_next = upd_cnt;
                cnt_next  = '0;
                step_next = '0;
            end
            else
            begin
                lo_next  = upd_lo;
                hi_next  = upd_hi;
                sum_next = upd_sum;
                cnt_next = upd_cnt;
            end
        end

        unique case (state_reg)
            DIV_IDLE:
            begin
                if (take && in_item.last)
                begin
                    state_next = DIV_RUN;
                end
            end
            DIV_RUN:
            begin
                // restoring divide, one quotient bit per cycle in each lane
                for (int a = 0; a < AXES; a++)
                begin
                    if (!diff[a][CNT_WIDTH])
                    begin
                        rem_next[a] = diff[a][CNT_WIDTH-1:0];
                        dvd_next[a] = {dvd_reg[a][SUM_WIDTH-2:0], 1'b1};
                    end
                    else
                    begin
                        rem_next[a] = rsh[a][CNT_WIDTH-1:0];
                        dvd_next[a] = {dvd_reg[a][SUM_WIDTH-2:0], 1'b0};
                    end
                end
                step_next = step_reg + 1'b1;
                if (step_reg == STEP_WIDTH'(SUM_WIDTH - 1))
                begin
                    state_next = DIV_DONE;
                end
            end
            DIV_DONE:
            begin
                out_valid = 1'b1;
                if (out_ready)
                begin
                    state_next = DIV_IDLE;
                end
            end
            default:
            begin
                state_next = DIV_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= DIV_IDLE;
            for (int a = 0; a < AXES; a++)
            begin
                lo_reg[a]  <= COORD_HI;
                hi_reg[a]  <= COORD_LO;
                sum_reg[a] <= '0;
            end
            cnt_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            lo_reg    <= lo_next;
            hi_reg    <= hi_next;
            sum_reg   <= sum_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        res_lo_reg <= res_lo_next;
        res_hi_reg <= res_hi_next;
        dvd_reg    <= dvd_next;
        rem_reg    <= rem_next;
        neg_reg    <= neg_next;
        dcnt_reg   <= dcnt_next;
        step_reg   <= step_next;
    end

    assign min_x  = res_lo_reg[0];
    assign min_y  = res_lo_reg[1];
    assign min_z  = res_lo_reg[2];
    assign max_x  = res_hi_reg[0];
    assign max_y  = res_hi_reg[1];
    assign max_z  = res_hi_reg[2];
    assign mean_x = neg_reg[0] ? -dvd_reg[0][COORD_WIDTH-1:0] : dvd_reg[0][COORD_WIDTH-1:0];
    assign mean_y = neg_reg[1] ? -dvd_reg[1][COORD_WIDTH-1:0] : dvd_reg[1][COORD_WIDTH-1:0];
    assign mean_z = neg_reg[2] ? -dvd_reg[2][COORD_WIDTH-1:0] : dvd_reg[2][COORD_WIDTH-1:0];

endmodule

>>> sv/transformed_point_bounds_centroid_core.sv
`timescale 1ns / 1ps
// Point-cloud bounds and centroid. Each input transfer carries one Q15.8 point;
// the block applies the affine transform held in the six registers (three
// signed Q3.12 weights per output axis plus a Q15.8 offset, result floored
// and saturated to 24 bits), keeps the running per-axis min, max and sum,
// and on the point flagged last_point returns one result: the bounding box
// and the centroid (sum / count, truncated toward zero), then starts a new
// cloud. Points past 65536 in one cloud are dropped, but a last_point still
// closes the cloud. Ordinary points are taken one per cycle while the queue
// has room; input passes a 4-entry queue and a two-stage transform pipe (9
// multipliers, then sum/offset/saturate) before the accumulators. A last
// point starts a restoring divider, one quotient bit per cycle for all three
// axes at once; the centroid is held from the end of the divide until the
// result transfer. Points of the next cloud keep flowing meanwhile; only its
// last point waits for the divider to be free. Configuration registers sit at
// byte address 8*i on a 64-bit APB port and may be written only while idle.
module transformed_point_bounds_centroid_core
    import tpbc_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,

    // configuration port
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0] prdata,
    output logic              pready,

    // point input
    input  logic              in_valid,
    output logic              in_ready,
    input  coord_t            x_in,
    input  coord_t            y_in,
    input  coord_t            z_in,
    input  logic              last_point,

    // result output
    output logic              out_valid,
    input  logic              out_ready,
    output coord_t            min_x,
    output coord_t            min_y,
    output coord_t            min_z,
    output coord_t            max_x,
    output coord_t            max_y,
    output coord_t            max_z,
    output coord_t            mean_x,
    output coord_t            mean_y,
    output coord_t            mean_z
);

    cfg_t   cfg;
    point_t in_item;
    point_t q_item;
    logic   q_valid;
    logic   q_ready;
    point_t t_item;
    logic   t_valid;
    logic   t_ready;

    // APB never stalls
    assign pready = 1'b1;

    tpbc_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .cfg     (cfg)
    );

    // front: input transfers land in a short queue so the back end can stall
    assign in_item.c[0] = x_in;
    assign in_item.c[1] = y_in;
    assign in_item.c[2] = z_in;
    assign in_item.last = last_point;

    tpbc_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_item   (in_item),
        .out_valid (q_valid),
        .out_ready (q_ready),
        .out_item  (q_item)
    );

    // back: transform pipe, then accumulators and centroid divider
    tpbc_xform u_xform (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .in_valid  (q_valid),
        .in_ready  (q_ready),
        .in_item   (q_item),
        .out_valid (t_valid),
        .out_ready (t_ready),
        .out_item  (t_item)
    );

    tpbc_accum u_accum (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (t_valid),
        .in_ready  (t_ready),
        .in_item   (t_item),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .min_x     (min_x),
        .min_y     (min_y),
        .min_z     (min_z),
        .max_x     (max_x),
        .max_y     (max_y),
        .max_z     (max_z),
        .mean_x    (mean_x),
        .mean_y    (mean_y),
        .mean_z    (mean_z)
    );

endmodule

>>> test/tb_top.sv
`timescale 1ns / 1ps
module tb_top;
    import tpbc_pkg::*;

    // Idle cycles allowed before a config write: queue + transform pipe + divider.
    localparam int SETTLE_CYCLES   = 64;
    // Long receiver hold-off used to back the block up into its input.
    localparam int HOLD_OFF_CYCLES = 400;
    // Cycles without any transfer before the run is declared hung.
    localparam int WATCHDOG_LIMIT  = 3000;
    localparam int PHASES          = 6;
    localparam int ITEMS_PER_PHASE = 275;

    // One closed cloud: bounding box plus centroid, index 0 is the x axis.
    typedef struct packed {
        coord_t [AXES-1:0] lo;
        coord_t [AXES-1:0] hi;
        coord_t [AXES-1:0] mean;
    } cloud_box_t;

    // Tracks the transform registers and the open cloud, and keeps the boxes
    // that closed clouds owe on the result channel, oldest first.
    class bounds_scoreboard;
        logic [WSET_WIDTH-1:0] weights [AXES];
        coord_t                offsets [AXES];
        coord_t                lowest  [AXES];
        coord_t                highest [AXES];
        longint                coord_total [AXES];
        int                    n_points;
        cloud_box_t            expected_boxes [$];
        int                    err_count;

        function new();
            weights[0] = WSET_WIDTH'(WEIGHT_ONE);
            weights[1] = WSET_WIDTH'(WEIGHT_ONE) << WEIGHT_WIDTH;
            weights[2] = WSET_WIDTH'(WEIGHT_ONE) << (2 * WEIGHT_WIDTH);
            for (int a = 0; a < AXES; a++)
                offsets[a] = '0;
            err_count = 0;
            clear_cloud();
        endfunction

        function void clear_cloud();
            for (int a = 0; a < AXES; a++)
            begin
                lowest[a]      = COORD_HI;
                highest[a]     = COORD_LO;
                coord_total[a] = 0;
            end
            n_points = 0;
        endfunction

        function void set_reg(reg_idx_t idx, logic [APB_DW-1:0] val);
            case (idx)
                REG_X_WEIGHTS: weights[0] = val[WSET_WIDTH-1:0];
                REG_Y_WEIGHTS: weights[1] = val[WSET_WIDTH-1:0];
                REG_Z_WEIGHTS: weights[2] = val[WSET_WIDTH-1:0];
                REG_X_OFFSET:  offsets[0] = val[COORD_WIDTH-1:0];
                REG_Y_OFFSET:  offsets[1] = val[COORD_WIDTH-1:0];
                REG_Z_OFFSET:  offsets[2] = val[COORD_WIDTH-1:0];
            endcase
        endfunction

        // Exact dot product, floor to Q.8, add offset, clamp to 24 bits.
        function coord_t transform_axis(int a, coord_t p [AXES]);
            longint acc;
            longint t;
            acc = 0;
            for (int b = 0; b < AXES; b++)
                acc += longint'($signed(weights[a][WEIGHT_WIDTH*b +: WEIGHT_WIDTH]))
                       * longint'(p[b]);
            t = (acc >>> FRAC_SHIFT) + longint'(offsets[a]);
            if (t > longint'(COORD_HI))
                t = longint'(COORD_HI);
            if (t < longint'(COORD_LO))
                t = longint'(COORD_LO);
            return coord_t'(t);
        endfunction

        function void note_point(coord_t x, coord_t y, coord_t z, logic last);
            coord_t     p [AXES];
            coord_t     t;
            cloud_box_t box;
            p[0] = x;
            p[1] = y;
            p[2] = z;
            // past MAX_POINTS the cloud is frozen, but last still closes it
            if (n_points < MAX_POINTS)
            begin
                for (int a = 0; a < AXES; a++)
                begin
                    t = transform_axis(a, p);
                    if (t < lowest[a])
                        lowest[a] = t;
                    if (t > highest[a])
                        highest[a] = t;
                    coord_total[a] += longint'(t);
                end
                n_points++;
            end
            if (last)
            begin
                for (int a = 0; a < AXES; a++)
                begin
                    box.lo[a]   = lowest[a];
                    box.hi[a]   = highest[a];
                    // signed divide truncates toward zero
                    box.mean[a] = coord_t'(coord_total[a] / longint'(n_points));
                end
                expected_boxes.push_back(box);
                clear_cloud();
            end
        endfunction

        function void compare_field(string name, coord_t want, coord_t got);
            if (got !== want)
            begin
                $error("%s: expected %0d, got %0d", name, want, got);
                err_count++;
            end
        endfunction

        function void check_result(cloud_box_t got);
            cloud_box_t want;
            string      ax [AXES];
            ax = '{"x", "y", "z"};
            if (expected_boxes.size() == 0)
            begin
                $error("result transfer with no closed cloud pending");
                err_count++;
                return;
            end
            want = expected_boxes.pop_front();
            for (int a = 0; a < AXES; a++)
            begin
                compare_field({"min_", ax[a]}, want.lo[a], got.lo[a]);
                compare_field({"max_", ax[a]}, want.hi[a], got.hi[a]);
                compare_field({"mean_", ax[a]}, want.mean[a], got.mean[a]);
            end
        endfunction
    endclass

    logic              clk;
    logic              rst_n;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [APB_AW-1:0] paddr;
    logic [APB_DW-1:0] pwdata;
    logic [APB_DW-1:0] prdata;
    logic              pready;
    logic              in_valid;
    logic              in_ready;
    coord_t            x_in;
    coord_t            y_in;
    coord_t            z_in;
    logic              last_point;
    logic              out_valid;
    logic              out_ready;
    coord_t            min_x;
    coord_t            min_y;
    coord_t            min_z;
    coord_t            max_x;
    coord_t            max_y;
    coord_t            max_z;
    coord_t            mean_x;
    coord_t            mean_y;
    coord_t            mean_z;

    bounds_scoreboard sb = new();

    bit gapless;       // sender offers back to back while set
    int burst_left;    // transfers left in the current sender burst
    bit hold_off_req;  // asks the receiver for one long hold-off
    int idle_cycles;

    transformed_point_bounds_centroid_core dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .x_in       (x_in),
        .y_in       (y_in),
        .z_in       (z_in),
        .last_point (last_point),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .min_x      (min_x),
        .min_y      (min_y),
        .min_z      (min_z),
        .max_x      (max_x),
        .max_y      (max_y),
        .max_z      (max_z),
        .mean_x     (mean_x),
        .mean_y     (mean_y),
        .mean_z     (mean_z)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Monitor and watchdog. Values read here at the edge are the pre-edge
    // values, since every driver in this bench updates by NBA.
    always @(posedge clk)
    begin : monitor
        cloud_box_t got;
        if (rst_n)
        begin
            if (in_valid && in_ready)
                sb.note_point(x_in, y_in, z_in, last_point);
            if (out_valid && out_ready)
            begin
                got.lo   = {min_z, min_y, min_x};
                got.hi   = {max_z, max_y, max_x};
                got.mean = {mean_z, mean_y, mean_x};
                sb.check_result(got);
            end
            if ((in_valid && in_ready) || (out_valid && out_ready) || (psel && penable))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("tb_top: errors");
                $finish;
            end
        end
    end

    // Result receiver: random stretches of always-ready, coin-flip, stalled
    // and sparse-ready, plus one long hold-off on request.
    initial
    begin
        int stretch;
        int mode;
        stretch = 0;
        mode    = 0;
        out_ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_off_req)
            begin
                out_ready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(posedge clk);
                hold_off_req = 1'b0;
            end
            else
            begin
                if (stretch == 0)
                begin
                    mode    = $urandom_range(0, 3);
                    stretch = $urandom_range(1, 40);
                end
                stretch--;
                case (mode)
                    0:       out_ready <= 1'b1;
                    1:       out_ready <= 1'($urandom_range(0, 1));
                    2:       out_ready <= 1'b0;
                    default: out_ready <= ($urandom_range(0, 3) == 0);
                endcase
            end
        end
    end

    // APB write: setup phase, then access phase until pready, then psel drops so writes never share a step.
    task automatic apb_write(reg_idx_t idx, logic [APB_DW-1:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, {REG_LSB{1'b0}}};
        pwdata  <= val;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        sb.set_reg(idx, val);
        @(posedge clk);
    endtask

    task automatic set_transform(logic [WSET_WIDTH-1:0] wx, logic [WSET_WIDTH-1:0] wy,
                                 logic [WSET_WIDTH-1:0] wz, coord_t ox, coord_t oy,
                                 coord_t oz);
        apb_write(REG_X_WEIGHTS, APB_DW'(wx));
        apb_write(REG_Y_WEIGHTS, APB_DW'(wy));
        apb_write(REG_Z_WEIGHTS, APB_DW'(wz));
        apb_write(REG_X_OFFSET,  APB_DW'(ox));
        apb_write(REG_Y_OFFSET,  APB_DW'(oy));
        apb_write(REG_Z_OFFSET,  APB_DW'(oz));
    endtask

    // Offer one point; returns at the edge where the transfer happened.
    task automatic send_point(coord_t x, coord_t y, coord_t z, logic last);
        int gap;
        if (!gapless && burst_left == 0)
        begin
            gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            burst_left = $urandom_range(1, 24);
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        if (burst_left > 0)
            burst_left--;
        in_valid   <= 1'b1;
        x_in       <= x;
        y_in       <= y;
        z_in       <= z;
        last_point <= last;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
    endtask

    // Sender pause until every owed box is back; with settle, also let
    // the divider and pipe go quiet so the registers may be rewritten.
    task automatic wait_results(bit settle);
        in_valid <= 1'b0;
        @(posedge clk);
        while (sb.expected_boxes.size() != 0)
            @(posedge clk);
        if (settle)
            repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    function automatic coord_t rand_coord();
        case ($urandom_range(0, 11))
            0:       return COORD_HI;
            1:       return COORD_LO;
            2:       return coord_t'(int'($urandom_range(0, 1024)) - 512);
            3:       return '0;
            default: return coord_t'($urandom);
        endcase
    endfunction

    function automatic logic [WEIGHT_WIDTH-1:0] rand_weight();
        case ($urandom_range(0, 7))
            0:       return 16'h7FFF;
            1:       return 16'h8000;
            2:       return 16'h0000;
            3:       return WEIGHT_ONE;
            4:       return -WEIGHT_ONE;
            5, 6:    return WEIGHT_WIDTH'($urandom_range(0, 16'h2000)) - WEIGHT_ONE;
            default: return WEIGHT_WIDTH'($urandom);
        endcase
    endfunction

    task automatic random_transform();
        set_transform({rand_weight(), rand_weight(), rand_weight()},
                      {rand_weight(), rand_weight(), rand_weight()},
                      {rand_weight(), rand_weight(), rand_weight()},
                      rand_coord(), rand_coord(), rand_coord());
    endtask

    initial
    begin
        int n;
        int len;
        psel         <= 1'b0;
        penable      <= 1'b0;
        pwrite       <= 1'b0;
        paddr        <= '0;
        pwdata       <= '0;
        in_valid     <= 1'b0;
        x_in         <= '0;
        y_in         <= '0;
        z_in         <= '0;
        last_point   <= 1'b0;
        rst_n        <= 1'b0;
        gapless      = 1'b0;
        burst_left   = 0;
        hold_off_req = 1'b0;
        idle_cycles  = 0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset transform is identity. Single-point clouds at both extremes,
        // a negative centroid that must truncate toward zero, and
        // alternating bit patterns on every coordinate bit.
        send_point(COORD_HI, COORD_HI, COORD_HI, 1'b1);
        send_point(COORD_LO, COORD_LO, COORD_LO, 1'b1);
        send_point(24'sd0, 24'sd0, 24'sd0, 1'b0);
        send_point(-24'sd1, 24'sd1, -24'sd3, 1'b0);
        send_point(-24'sd4, 24'sd2, 24'sd1, 1'b1);
        send_point(24'h555555, 24'hAAAAAA, 24'h000FFF, 1'b0);
        send_point(24'hAAAAAA, 24'h555555, 24'hFFF000, 1'b1);
        wait_results(1'b1);

        // Extreme weights and offsets: saturation high on x, low on y,
        // and tiny weights on z so the floor of a fraction shows.
        set_transform({16'h7FFF, 16'h7FFF, 16'h7FFF}, {16'h8000, 16'h8000, 16'h8000},
                      {16'h0000, 16'hFFFF, 16'h0001}, COORD_HI, COORD_LO, -24'sd1);
        send_point(COORD_HI, COORD_HI, COORD_HI, 1'b0);
        send_point(COORD_LO, COORD_LO, COORD_LO, 1'b0);
        send_point(COORD_HI, COORD_LO, 24'sd0, 1'b0);
        send_point(24'sd1, 24'sd0, -24'sd1, 1'b0);
        send_point(-24'sd1, 24'sd0, 24'sd0, 1'b1);
        wait_results(1'b1);

        // Axis swaps and sign flips, small offsets; rounding of -1/4096
        // must go to -1 and of 1/4096 to 0.
        set_transform({16'h0000, 16'h0000, 16'h0001}, {WEIGHT_ONE, 16'h0000, 16'h0000},
                      {16'h0000, 16'h0000, -WEIGHT_ONE}, -24'sd256, 24'sd256, 24'sd0);
        send_point(-24'sd1, 24'sd5, 24'sd7, 1'b0);
        send_point(24'sd1, -24'sd5, -24'sd7, 1'b0);
        send_point(24'sd4095, 24'sd0, 24'sd0, 1'b0);
        send_point(-24'sd4097, 24'sd0, 24'sd0, 1'b1);
        wait_results(1'b1);

        // Random clouds, mostly short, under a fresh transform per phase.
        // Phase 1 and 2 pin every register at its top and bottom value.
        for (int phase = 0; phase < PHASES; phase++)
        begin
            case (phase)
                1: set_transform({3{16'h7FFF}}, {3{16'h7FFF}}, {3{16'h7FFF}},
                                 COORD_HI, COORD_HI, COORD_HI);
                2: set_transform({3{16'h8000}}, {3{16'h8000}}, {3{16'h8000}},
                                 COORD_LO, COORD_LO, COORD_LO);
                default: random_transform();
            endcase
            gapless = (phase == 4);
            // receiver backs off while points keep coming, so the input stalls
            if (phase == 2)
                hold_off_req = 1'b1;
            n = 0;
            while (n < ITEMS_PER_PHASE)
            begin
                len = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 60)
                                                  : $urandom_range(1, 8);
                for (int k = 0; k < len; k++)
                    send_point(rand_coord(), rand_coord(), rand_coord(), k == len - 1);
                n += len;
                if ($urandom_range(0, 15) == 0)
                    wait_results(1'b0);
            end
            wait_results(1'b1);
        end

        if (sb.err_count == 0)
            $display("tb_top: clean");
        else
            $display("tb_top: errors");
        $finish;
    end

endmodule
